// ----- rtl/bounded_task_priority_queue_core_assert.svh -----
// Assertion macros used by the checker file.
`ifndef BOUNDED_TASK_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define BOUNDED_TASK_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define BTPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define BTPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/btpq_pkg.sv -----
// ---------------------------------------------------------------------------
// btpq_pkg
// Types and constants of the bounded task priority queue.
// ---------------------------------------------------------------------------
package btpq_pkg;

    localparam int DEF_QUEUE_DEPTH   = 256;
    localparam int DEF_KEY_WIDTH     = 16;
    localparam int DEF_PAYLOAD_WIDTH = 64;
    localparam int UB_W    = 16;
    localparam int LVL_W   = 10;
    localparam int PAY_W   = 64;
    localparam int STAT_W  = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_GET    = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_POP,
        S_DONE
    } btpq_state_t;

endpackage

// ----- rtl/btpq_if.sv -----
// ---------------------------------------------------------------------------
// btpq_req_if / btpq_rsp_if
// Valid/ready request and result channels of the priority queue.
// ---------------------------------------------------------------------------
interface btpq_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] upper_bound;
    logic [15:0] lower_bound;
    logic [9:0]  depth_level;
    logic [63:0] payload;
    logic [15:0] threshold;
    modport source (output valid, op, upper_bound, lower_bound, depth_level, payload,
                    threshold, input ready);
    modport sink (input valid, op, upper_bound, lower_bound, depth_level, payload,
                  threshold, output ready);
endinterface

interface btpq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] out_upper_bound;
    logic [15:0] out_lower_bound;
    logic [9:0]  out_level;
    logic [63:0] out_payload;
    modport source (output valid, status, out_upper_bound, out_lower_bound, out_level,
                    out_payload, input ready);
    modport sink (input valid, status, out_upper_bound, out_lower_bound, out_level,
                  out_payload, output ready);
endinterface

// ----- rtl/btpq_mem.sv -----
// ---------------------------------------------------------------------------
// btpq_mem
// Entry store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module btpq_mem
    import btpq_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH,
    parameter int WIDTH = 32
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/bounded_task_priority_queue_core.sv -----
// ---------------------------------------------------------------------------
// bounded_task_priority_queue_core
// Sorted task queue for branch-and-bound, with threshold pruning on get.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one request: op 0 inserts a task (keys, level, payload),
//   op 1 gets the best task against threshold. rsp returns exactly one
//   result per request: status, and the popped task on a successful get.
//   Tasks live in one single-port-read memory sorted ascending, head at
//   the top address. An insert reads the entry below the free slot one per
//   cycle and moves it up while it outranks the new task, moving at most
//   QUEUE_DEPTH - 1 entries. A get makes one memory read of the head; a full
//   insert or a get on an empty queue reads no entry. Pruning, when the
//   head's upper bound is below threshold, zeroes the count and returns EMPTY.
//   One request is in flight at a time; req.ready is low while one works
//   and while its result waits in the output register for rsp.ready.
//   Reset clears the count and control state; the memory needs no clearing
//   pass since only written entries below the count are read.
// ---------------------------------------------------------------------------
module bounded_task_priority_queue_core
    import btpq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
    parameter int KEY_WIDTH     = DEF_KEY_WIDTH,
    parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    btpq_req_if.sink   req,
    btpq_rsp_if.source rsp
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = 2 * KEY_WIDTH + LVL_W + PAYLOAD_WIDTH;

    btpq_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pos_reg, pos_next;        // free slot during insert
    logic [KEY_WIDTH-1:0] up_reg, lo_reg;
    logic [LVL_W-1:0] lvl_reg;
    logic [PAYLOAD_WIDTH-1:0] pay_reg;
    logic [STAT_W-1:0] stat_reg, stat_next;
    logic [EW-1:0] task_reg;
    logic rvalid_reg;                         // read data of pos-1 is valid

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic [KEY_WIDTH-1:0] r_up, r_lo;
    logic above;
    logic acc;

    assign acc = req.valid && req.ready;
    assign r_up = rdata[EW-1 -: KEY_WIDTH];
    assign r_lo = rdata[EW-KEY_WIDTH-1 -: KEY_WIDTH];
    assign above = (r_up != up_reg) ? (r_up > up_reg) : (r_lo > lo_reg);

    btpq_mem #(.DEPTH(QUEUE_DEPTH), .WIDTH(EW)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (req.op == OP_INSERT)
                    begin
                        state_next = (count_reg >= CW'(QUEUE_DEPTH)) ? S_DONE : S_SHIFT;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_POP;
                    end
                end
            end
            S_SHIFT:
            begin
                if (pos_reg == '0 || (rvalid_reg && !above))
                begin
                    state_next = S_DONE;
                end
            end
            S_POP:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory port control and datapath
    always_comb
    begin
        we         = 1'b0;
        waddr      = pos_reg[AW-1:0];
        wdata      = {up_reg, lo_reg, lvl_reg, pay_reg};
        raddr      = AW'(count_reg - CW'(1));
        count_next = count_reg;
        pos_next   = pos_reg;
        stat_next  = stat_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    stat_next = ST_OK;
                    pos_next  = count_reg;
                    if (req.op == OP_INSERT && count_reg >= CW'(QUEUE_DEPTH))
                    begin
                        stat_next = ST_FULL;
                    end
                    else if (req.op == OP_GET && count_reg == '0)
                    begin
                        stat_next = ST_EMPTY;
                    end
                end
            end
            S_SHIFT:
            begin
                // read of pos-1 issued last cycle; move up or drop task in
                raddr = AW'(pos_reg - CW'(2));
                if (pos_reg == '0 || (rvalid_reg && !above))
                begin
                    we         = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                else if (rvalid_reg)
                begin
                    we       = 1'b1;
                    wdata    = rdata;
                    pos_next = pos_reg - CW'(1);
                end
            end
            S_POP:
            begin
                if (r_up >= up_reg)
                begin
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    stat_next  = ST_EMPTY;
                    count_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rvalid_reg <= (state_reg == S_IDLE && acc)
                          || (state_reg == S_SHIFT && rvalid_reg && above
                              && pos_reg != '0);
        end
    end

    // Payload registers; up_reg holds the threshold on a get
    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        stat_reg <= stat_next;
        if (state_reg == S_IDLE && acc)
        begin
            up_reg   <= (req.op == OP_INSERT) ? req.upper_bound[KEY_WIDTH-1:0]
                                              : req.threshold[KEY_WIDTH-1:0];
            lo_reg   <= req.lower_bound[KEY_WIDTH-1:0];
            lvl_reg  <= req.depth_level;
            pay_reg  <= req.payload[PAYLOAD_WIDTH-1:0];
            task_reg <= '0;
        end
        else if (state_reg == S_POP && r_up >= up_reg)
        begin
            task_reg <= rdata;
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_DONE);
    assign rsp.status = stat_reg;
    assign rsp.out_upper_bound = UB_W'(task_reg[EW-1 -: KEY_WIDTH]);
    assign rsp.out_lower_bound = UB_W'(task_reg[EW-KEY_WIDTH-1 -: KEY_WIDTH]);
    assign rsp.out_level = task_reg[PAYLOAD_WIDTH +: LVL_W];
    assign rsp.out_payload = PAY_W'(task_reg[PAYLOAD_WIDTH-1:0]);
endmodule

// ----- rtl/btpq_checker.sv -----
// ---------------------------------------------------------------------------
// btpq_checker
// Port-level checks of the priority queue core.
// ---------------------------------------------------------------------------
`include "bounded_task_priority_queue_core_assert.svh"

module btpq_checker
    import btpq_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] status,
    input logic [15:0] out_upper_bound
);
    `BTPQ_ASSERT_IMP(a_one_in_flight, clk, rst_n, rsp_valid, !req_ready, "ready during result")
    `BTPQ_ASSERT_NEXT(a_rsp_holds, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid, "result dropped")
    `BTPQ_ASSERT_IMP(a_status_code, clk, rst_n, rsp_valid,
        status == ST_OK || status == ST_EMPTY || status == ST_FULL, "bad status")
    `BTPQ_ASSERT_IMP(a_empty_zero, clk, rst_n, rsp_valid && status != ST_OK,
        out_upper_bound == '0, "fields set without task")
    `BTPQ_ASSERT_NEXT(a_accept_latency, clk, rst_n, req_valid && req_ready, !req_ready,
        "second request taken while one is in flight")
endmodule

bind bounded_task_priority_queue_core btpq_checker u_btpq_checker (
    .clk(clk), .rst_n(rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .status(rsp.status), .out_upper_bound(rsp.out_upper_bound)
);
